@@ design/smx_pkg.sv @@
// shared constants, opcode and error codes, stack tables and types of the stack machine
package smx_pkg;

    // sizes of the machine
    localparam int PROGRAM_WORDS = 4096;
    localparam int DATA_WORDS    = 1024;
    localparam int STACK_DEPTH   = 256;

    localparam int WORD_W = 32;
    localparam int OP_W   = 6;
    localparam int NPC_W  = 12;
    localparam int ERR_W  = 3;
    localparam int CFG_W  = 12;
    localparam int PC_W   = $clog2(PROGRAM_WORDS);
    localparam int DA_W   = $clog2(DATA_WORDS);
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);

    // stream payload widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 56;

    // opcodes
    localparam logic [OP_W-1:0] OP_NOP    = 6'd0;
    localparam logic [OP_W-1:0] OP_ASSGN  = 6'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd2;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd3;
    localparam logic [OP_W-1:0] OP_MUL    = 6'd4;
    localparam logic [OP_W-1:0] OP_DIV    = 6'd5;
    localparam logic [OP_W-1:0] OP_MOD    = 6'd6;
    localparam logic [OP_W-1:0] OP_CSIGN  = 6'd7;
    localparam logic [OP_W-1:0] OP_AND    = 6'd8;
    localparam logic [OP_W-1:0] OP_OR     = 6'd9;
    localparam logic [OP_W-1:0] OP_NOT    = 6'd10;
    localparam logic [OP_W-1:0] OP_COMP   = 6'd11;
    localparam logic [OP_W-1:0] OP_COPY   = 6'd12;
    localparam logic [OP_W-1:0] OP_PUSH   = 6'd13;
    localparam logic [OP_W-1:0] OP_PUSHI  = 6'd14;
    localparam logic [OP_W-1:0] OP_REMOVE = 6'd15;
    localparam logic [OP_W-1:0] OP_POP    = 6'd16;
    localparam logic [OP_W-1:0] OP_INC    = 6'd17;
    localparam logic [OP_W-1:0] OP_DEC    = 6'd18;
    localparam logic [OP_W-1:0] OP_SETFR  = 6'd19;
    localparam logic [OP_W-1:0] OP_INCFR  = 6'd20;
    localparam logic [OP_W-1:0] OP_DECFR  = 6'd21;
    localparam logic [OP_W-1:0] OP_JUMP   = 6'd22;
    localparam logic [OP_W-1:0] OP_BLT    = 6'd23;
    localparam logic [OP_W-1:0] OP_BLE    = 6'd24;
    localparam logic [OP_W-1:0] OP_BEQ    = 6'd25;
    localparam logic [OP_W-1:0] OP_BNE    = 6'd26;
    localparam logic [OP_W-1:0] OP_BGE    = 6'd27;
    localparam logic [OP_W-1:0] OP_BGT    = 6'd28;
    localparam logic [OP_W-1:0] OP_CALL   = 6'd29;
    localparam logic [OP_W-1:0] OP_RET    = 6'd30;
    localparam logic [OP_W-1:0] OP_HALT   = 6'd31;
    localparam logic [OP_W-1:0] OP_INPUT  = 6'd32;
    localparam logic [OP_W-1:0] OP_OUTPUT = 6'd33;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZ  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_ADDR  = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EX   = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
    } t_div_rsp;

    // words popped by each opcode
    function automatic logic [1:0] pops_of(input logic [OP_W-1:0] op);
        case (op)
            OP_ASSGN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_AND, OP_OR, OP_COMP: pops_of = 2'd2;
            OP_CSIGN, OP_NOT, OP_COPY, OP_REMOVE, OP_POP, OP_INC, OP_DEC,
            OP_BLT, OP_BLE, OP_BEQ, OP_BNE, OP_BGE, OP_BGT,
            OP_RET, OP_INPUT, OP_OUTPUT: pops_of = 2'd1;
            default: pops_of = 2'd0;
        endcase
    endfunction

    // words pushed by each opcode
    function automatic logic [1:0] push_of(input logic [OP_W-1:0] op);
        case (op)
            OP_COPY: push_of = 2'd2;
            OP_ASSGN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CSIGN,
            OP_AND, OP_OR, OP_NOT, OP_COMP, OP_PUSH, OP_PUSHI,
            OP_INC, OP_DEC, OP_CALL: push_of = 2'd1;
            default: push_of = 2'd0;
        endcase
    endfunction

endpackage

@@ design/stack_machine_execute.sv @@
// top level of the stack machine: sequencer, stack and data memories, result register
//
// Input stream (i_s_*): one instruction per request, fields opcode, operand and
// input_value. Output stream (o_m_*): one result per instruction with next_pc,
// out_valid, out_value, halted and error_code. Config channel (i_cfg_*): the
// start address, to be written while the block is idle, which the block itself does not
// enforce; it is loaded into the pc by the first instruction after reset.
// An instruction is taken while the sequencer is idle; the stack and data
// memories are read at that edge and the result is committed from the execute
// state once the output register is free, after which the next request is taken.
// DIV and MOD with a non-zero divisor wait in the divider state for the shared
// iterative divider.
// A result waits in the output register while the receiver stalls; the next
// instruction is still taken, and its commit waits until that register frees.
// Reset clears the stack pointer, the halt flag and the handshake state; the
// stack and data memories hold no defined contents until written.
module stack_machine_execute (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // opcode, operand, input_value
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [smx_pkg::IN_W-1:0]    i_s_tdata,
    // next_pc, out_valid, out_value, halted, error_code
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [smx_pkg::OUT_W-1:0]   o_m_tdata,
    // start_address
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [smx_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int W    = smx_pkg::WORD_W;
    localparam int PC_W = smx_pkg::PC_W;
    localparam int DA_W = smx_pkg::DA_W;
    localparam int SA_W = smx_pkg::SA_W;
    localparam int SP_W = smx_pkg::SP_W;

    smx_pkg::t_state r_state;
    logic [smx_pkg::OP_W-1:0]  r_op;
    logic [W-1:0]              r_arg;
    logic [W-1:0]              r_inval;
    logic [SP_W-1:0]           r_sp;
    logic [PC_W-1:0]           r_pc;
    logic                      r_started;
    logic                      r_halt;
    logic [smx_pkg::CFG_W-1:0] r_boot_pc;
    logic                      r_out_valid;
    logic [smx_pkg::OUT_W-1:0] r_out_data;

    logic                      s_accept;
    logic                      out_free;
    logic [W-1:0]              st_top;
    logic [W-1:0]              st_sec;
    logic [W-1:0]              dm_rd;
    logic                      st_we;
    logic [SA_W-1:0]           st_waddr;
    logic                      dm_we;
    logic [DA_W-1:0]           dm_waddr;
    logic [W-1:0]              dm_wdata;
    smx_pkg::t_div_req         div_req;
    smx_pkg::t_div_rsp         div_rsp;

    logic [smx_pkg::OP_W-1:0]  op;
    logic [1:0]                pops;
    logic [1:0]                pushes;
    logic [PC_W-1:0]           cur_pc;
    logic [PC_W-1:0]           pc_inc;
    logic [PC_W-1:0]           n_pc;
    logic [SP_W:0]             new_sp;
    logic                      under;
    logic                      over;
    logic                      take;
    logic                      bad_addr;
    logic                      active;
    logic                      is_div;
    logic                      divz;
    logic                      div_start;
    logic                      commit;
    logic [W-1:0]              res;
    logic                      outvalid;
    logic [W-1:0]              outv;
    logic                      n_halt;
    logic [smx_pkg::ERR_W-1:0] err;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == smx_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // operand stack, two copies for the top and second reads
    smx_ram #(.DEPTH(smx_pkg::STACK_DEPTH), .WIDTH(W)) u_stack_top (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (res),
        .i_re    (s_accept),
        .i_raddr (r_sp[SA_W-1:0] - SA_W'(1)),
        .o_rdata (st_top)
    );

    smx_ram #(.DEPTH(smx_pkg::STACK_DEPTH), .WIDTH(W)) u_stack_sec (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (res),
        .i_re    (s_accept),
        .i_raddr (r_sp[SA_W-1:0] - SA_W'(2)),
        .o_rdata (st_sec)
    );

    // data memory, read at the operand address, written only at commit
    smx_ram #(.DEPTH(smx_pkg::DATA_WORDS), .WIDTH(W)) u_data (
        .i_clk   (i_clk),
        .i_we    (dm_we && commit),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (s_accept),
        .i_raddr (i_s_tdata[smx_pkg::OP_W +: DA_W]),
        .o_rdata (dm_rd)
    );

    smx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // decode and checks
    always_comb begin
        op       = (r_op > smx_pkg::OP_OUTPUT) ? smx_pkg::OP_NOP : r_op;
        pops     = smx_pkg::pops_of(op);
        pushes   = smx_pkg::push_of(op);
        cur_pc   = r_started ? r_pc : PC_W'(r_boot_pc);
        pc_inc   = cur_pc + 1'b1;
        new_sp   = {1'b0, r_sp} - (SP_W + 1)'(pops) + (SP_W + 1)'(pushes);
        under    = r_sp < SP_W'(pops);
        over     = !under && (new_sp > (SP_W + 1)'(smx_pkg::STACK_DEPTH));
        take     = 1'b0;
        bad_addr = 1'b0;
        case (op)
            smx_pkg::OP_PUSH, smx_pkg::OP_POP:
                bad_addr = r_arg >= W'(smx_pkg::DATA_WORDS);
            smx_pkg::OP_ASSGN: bad_addr = st_sec >= W'(smx_pkg::DATA_WORDS);
            smx_pkg::OP_INPUT: bad_addr = st_top >= W'(smx_pkg::DATA_WORDS);
            smx_pkg::OP_JUMP, smx_pkg::OP_CALL:
                bad_addr = r_arg >= W'(smx_pkg::PROGRAM_WORDS);
            smx_pkg::OP_RET:   bad_addr = st_top >= W'(smx_pkg::PROGRAM_WORDS);
            smx_pkg::OP_BLT:   take = st_top[W-1];
            smx_pkg::OP_BLE:   take = st_top[W-1] || (st_top == '0);
            smx_pkg::OP_BEQ:   take = (st_top == '0);
            smx_pkg::OP_BNE:   take = (st_top != '0);
            smx_pkg::OP_BGE:   take = !st_top[W-1];
            smx_pkg::OP_BGT:   take = !st_top[W-1] && (st_top != '0);
            default: ;
        endcase
        if (take && (r_arg >= W'(smx_pkg::PROGRAM_WORDS))) begin
            bad_addr = 1'b1;
        end
        active    = !r_halt && !under && !over && !bad_addr;
        is_div    = (op == smx_pkg::OP_DIV) || (op == smx_pkg::OP_MOD);
        divz      = (st_top == '0);
        div_start = (r_state == smx_pkg::S_EX) && active && is_div && !divz;
        commit    = out_free && (((r_state == smx_pkg::S_EX) && !div_start) ||
                                 ((r_state == smx_pkg::S_DIV) && !div_rsp.busy));
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = st_sec;
    assign div_req.divisor  = st_top;

    // execute
    always_comb begin
        res      = '0;
        outvalid = 1'b0;
        outv     = '0;
        n_pc     = pc_inc;
        n_halt   = r_halt;
        dm_we    = 1'b0;
        dm_waddr = r_arg[DA_W-1:0];
        dm_wdata = st_top;
        err      = smx_pkg::ERR_NONE;
        case (op)
            smx_pkg::OP_ASSGN: begin
                res      = st_top;
                dm_we    = 1'b1;
                dm_waddr = st_sec[DA_W-1:0];
            end
            smx_pkg::OP_ADD:   res = st_sec + st_top;
            smx_pkg::OP_SUB:   res = st_sec - st_top;
            smx_pkg::OP_MUL:   res = st_sec * st_top;
            smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
                if (divz) begin
                    res = '0;
                    err = smx_pkg::ERR_DIVZ;
                end else begin
                    res = (op == smx_pkg::OP_DIV) ? div_rsp.quo : div_rsp.rem;
                end
            end
            smx_pkg::OP_CSIGN: res = '0 - st_top;
            smx_pkg::OP_AND:   res = W'((st_top != '0) && (st_sec != '0));
            smx_pkg::OP_OR:    res = W'((st_top != '0) || (st_sec != '0));
            smx_pkg::OP_NOT:   res = W'(st_top == '0);
            smx_pkg::OP_COMP: begin
                if ($signed(st_top) < $signed(st_sec)) begin
                    res = W'(1);
                end else if ($signed(st_sec) < $signed(st_top)) begin
                    res = '1;
                end
            end
            smx_pkg::OP_COPY:  res = st_top;
            smx_pkg::OP_PUSH:  res = dm_rd;
            smx_pkg::OP_PUSHI: res = r_arg;
            smx_pkg::OP_POP:   dm_we = 1'b1;
            smx_pkg::OP_INC:   res = st_top + 1'b1;
            smx_pkg::OP_DEC:   res = st_top - 1'b1;
            smx_pkg::OP_JUMP:  n_pc = r_arg[PC_W-1:0];
            smx_pkg::OP_BLT, smx_pkg::OP_BLE, smx_pkg::OP_BEQ,
            smx_pkg::OP_BNE, smx_pkg::OP_BGE, smx_pkg::OP_BGT: begin
                if (take) begin
                    n_pc = r_arg[PC_W-1:0];
                end
            end
            smx_pkg::OP_CALL: begin
                res  = {{(W - PC_W){1'b0}}, pc_inc};
                n_pc = r_arg[PC_W-1:0];
            end
            smx_pkg::OP_RET:   n_pc = st_top[PC_W-1:0];
            smx_pkg::OP_HALT:  n_halt = 1'b1;
            smx_pkg::OP_INPUT: begin
                dm_we    = 1'b1;
                dm_waddr = st_top[DA_W-1:0];
                dm_wdata = r_inval;
            end
            smx_pkg::OP_OUTPUT: begin
                outvalid = 1'b1;
                outv     = st_top;
            end
            default: ;
        endcase
        // held machine or fault overrides
        if (r_halt) begin
            res      = '0;
            outvalid = 1'b0;
            outv     = '0;
            n_pc     = cur_pc;
            dm_we    = 1'b0;
            err      = smx_pkg::ERR_NONE;
        end else if (!active) begin
            outvalid = 1'b0;
            outv     = '0;
            n_pc     = cur_pc;
            n_halt   = 1'b1;
            dm_we    = 1'b0;
            err      = under ? smx_pkg::ERR_UNDER :
                       over  ? smx_pkg::ERR_OVER  : smx_pkg::ERR_ADDR;
        end
    end

    assign st_we    = commit && active && (pushes != 2'd0);
    assign st_waddr = new_sp[SA_W-1:0] - SA_W'(1);

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smx_pkg::S_IDLE;
            r_sp        <= '0;
            r_started   <= 1'b0;
            r_halt      <= 1'b0;
            r_boot_pc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_boot_pc <= i_cfg_data;
            end
            case (r_state)
                smx_pkg::S_IDLE: begin
                    if (s_accept) begin
                        r_state <= smx_pkg::S_EX;
                    end
                end
                smx_pkg::S_EX: begin
                    if (div_start) begin
                        r_state <= smx_pkg::S_DIV;
                    end else if (commit) begin
                        r_state <= smx_pkg::S_IDLE;
                    end
                end
                smx_pkg::S_DIV: begin
                    if (commit) begin
                        r_state <= smx_pkg::S_IDLE;
                    end
                end
                default: r_state <= smx_pkg::S_IDLE;
            endcase
            if (commit) begin
                r_started   <= 1'b1;
                r_pc        <= n_pc;
                r_halt      <= n_halt;
                r_out_valid <= 1'b1;
                if (active) begin
                    r_sp <= new_sp[SP_W-1:0];
                end
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // instruction and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op    <= i_s_tdata[smx_pkg::OP_W-1:0];
            r_arg   <= i_s_tdata[smx_pkg::OP_W +: W];
            r_inval <= i_s_tdata[smx_pkg::OP_W + W +: W];
        end
        if (commit) begin
            r_out_data <= {7'b0, err, n_halt, outv, outvalid, smx_pkg::NPC_W'(n_pc)};
        end
    end

endmodule

@@ design/smx_ram.sv @@
// generic synchronous ram, one write port and one registered read port
module smx_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ design/smx_div.sv @@
// signed iterative divider, one quotient bit a cycle, truncating towards zero
module smx_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smx_pkg::t_div_req i_req,
    output smx_pkg::t_div_rsp o_rsp
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic          r_neg_q;
    logic          r_neg_r;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    // trial subtraction of one step
    assign rem_sh = {r_rem[W-1:0], r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_quo   <= i_req.dividend[W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
            r_den   <= i_req.divisor[W-1] ? (~i_req.divisor + 1'b1) : i_req.divisor;
            r_neg_q <= i_req.dividend[W-1] ^ i_req.divisor[W-1];
            r_neg_r <= i_req.dividend[W-1];
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // sign correction of the magnitudes
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign o_rsp.rem  = r_neg_r ? (~r_rem[W-1:0] + 1'b1) : r_rem[W-1:0];

endmodule

@@ design/smx_checker.sv @@
// port-level checker of the stack machine and its bind to the top level
module smx_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [smx_pkg::IN_W-1:0]    i_s_tdata,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [smx_pkg::OUT_W-1:0]   o_m_tdata,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [smx_pkg::CFG_W-1:0]   i_cfg_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result shown after reset");

    // one instruction at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while executing");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // an output value comes only from a clean, running step
    a_out_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[12]) |->
        ((o_m_tdata[48:46] == smx_pkg::ERR_NONE) && !o_m_tdata[45]))
        else $error("output value with error or halt");

    // stack and address faults stop the machine
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[48:46] != smx_pkg::ERR_NONE) &&
         (o_m_tdata[48:46] != smx_pkg::ERR_DIVZ)) |-> o_m_tdata[45])
        else $error("fault without halt");

endmodule

bind stack_machine_execute smx_checker u_smx_checker (.*);
